[rtl/ctd_pkg.sv]
// ----------------------------------------------------------------------------
// ctd_pkg: shared types and constants for the countdown timer display
//
// Holds the operation codes, the time-unit constants, the fixed-point
// reciprocals used for the constant divisions, and the packed payload
// structures of the input and result channels.
// ----------------------------------------------------------------------------
package ctd_pkg;

    // Operation codes carried in the input item.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;
    localparam logic [1:0] OP_RESET = 2'd3;

    // Time units.
    localparam int unsigned MS_PER_S      = 1000;
    localparam int unsigned MS_PER_CS     = 10;
    localparam int unsigned S_PER_MIN     = 60;
    localparam int unsigned MIN_PER_HOUR  = 60;
    localparam int unsigned HOURS_PER_DAY = 24;

    // Reciprocals: floor(n / d) == (n * RECIP) >> SHIFT, exact over the
    // range of n that reaches each divider.
    localparam logic [31:0] RECIP_S     = 32'd2199023256;  // /1000, n < 2^31
    localparam int unsigned SHIFT_S     = 41;
    localparam logic [26:0] RECIP_MIN   = 27'd71582789;    // /60, n < 2^22
    localparam int unsigned SHIFT_MIN   = 32;
    localparam logic [10:0] RECIP_CS    = 11'd1639;        // /10, n < 2^10
    localparam int unsigned SHIFT_CS    = 14;
    localparam logic [16:0] RECIP_HOUR  = 17'd69906;       // /60, n < 2^16
    localparam int unsigned SHIFT_HOUR  = 22;
    localparam logic [10:0] RECIP_DAY   = 11'd1366;        // /24, n < 2^10
    localparam int unsigned SHIFT_DAY   = 15;

    typedef struct packed {
        logic [1:0]  operation;
        logic [30:0] start_duration_ms;
    } t_in;

    typedef struct packed {
        logic [5:0] display_high;
        logic [5:0] display_mid;
        logic [6:0] display_low;
        logic       hours_shown;
        logic       running;
        logic       timer_set;
    } t_out;

endpackage

[rtl/countdown_timer_display.sv]
// ----------------------------------------------------------------------------
// countdown_timer_display: millisecond countdown timer with display formatting
//
// Applies tick, start, stop and reset operations to the timer state and
// returns the remaining time split into display digit groups.
// ----------------------------------------------------------------------------
// The block takes one operation per clock cycle while o_ready is high and
// presents one result for each, in order. The timer state is updated in the
// cycle the operation is accepted, so operations may follow each other back
// to back; the remaining time then passes through five register stages ahead
// of the output register that split it into hours, minutes, seconds and
// centiseconds with constant-reciprocal multipliers. Each stage moves forward
// whenever the stage after it is empty or moving, so bubbles close up and new
// operations are still taken while a finished result waits at the output, as
// long as one of the stages ahead of it is empty.
module countdown_timer_display
    import ctd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    // Timer state.
    logic        r_running, n_running;
    logic [30:0] r_duration, n_duration;
    logic [30:0] r_remain, n_remain;
    logic [30:0] n_value;
    logic        w_accept;

    // Stage valids, index 1 is the first stage and 6 the output register.
    logic [6:1] r_vld;
    logic [6:1] w_load;

    // Stage payloads; the flags are {running, timer_set}.
    logic [30:0] r1_value;
    logic [1:0]  r1_flags;
    logic [30:0] r2_value;
    logic [21:0] r2_sec;
    logic [1:0]  r2_flags;
    logic [9:0]  r3_ms;
    logic [21:0] r3_sec;
    logic [15:0] r3_min;
    logic [1:0]  r3_flags;
    logic [5:0]  r4_ss;
    logic [6:0]  r4_cs;
    logic [15:0] r4_min;
    logic [9:0]  r4_hour;
    logic [1:0]  r4_flags;
    logic [5:0]  r5_ss;
    logic [6:0]  r5_cs;
    logic [5:0]  r5_mm;
    logic [9:0]  r5_hour;
    logic [4:0]  r5_day;
    logic [1:0]  r5_flags;
    t_out        r_out;

    // Stage arithmetic.
    logic [62:0] w_prod_sec;
    logic [31:0] w_ms_full;
    logic [48:0] w_prod_min;
    logic [21:0] w_ss_full;
    logic [20:0] w_prod_cs;
    logic [32:0] w_prod_hour;
    logic [15:0] w_mm_full;
    logic [20:0] w_prod_day;
    logic [9:0]  w_hh_full;
    logic [4:0]  w_hh;
    t_out        n_out;

    // ------------------------------------------------------------------
    // Handshake: a stage loads when it is empty or its contents move on.
    // ------------------------------------------------------------------
    always_comb begin
        w_load[6] = !r_vld[6] || i_ready;
        for (int k = 5; k >= 1; k--) begin
            w_load[k] = !r_vld[k] || w_load[k+1];
        end
    end

    assign o_ready  = w_load[1];
    assign w_accept = i_valid && w_load[1];
    assign o_valid  = r_vld[6];
    assign o_data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_load[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= 6; k++) begin
                if (w_load[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Timer state update. The remaining time is tracked directly; while
    // stopped the stored duration is the remaining time.
    // ------------------------------------------------------------------
    always_comb begin
        n_running  = r_running;
        n_duration = r_duration;
        n_remain   = r_remain;
        case (i_data.operation)
            OP_TICK: begin
                if (r_running) begin
                    n_remain = r_remain - 31'd1;
                    // The count has run out, so the timer clears itself.
                    if (n_remain == '0) begin
                        n_running  = 1'b0;
                        n_duration = '0;
                    end
                end
            end
            OP_START: begin
                if (i_data.start_duration_ms != '0) begin
                    n_duration = i_data.start_duration_ms;
                    n_remain   = i_data.start_duration_ms;
                    n_running  = 1'b1;
                end else if (r_duration != '0) begin
                    n_remain  = r_duration;
                    n_running = 1'b1;
                end
            end
            OP_STOP: begin
                if (r_running) begin
                    n_duration = r_remain;
                    n_running  = 1'b0;
                end
            end
            OP_RESET: begin
                n_running  = 1'b0;
                n_duration = '0;
                n_remain   = '0;
            end
            default: begin
                n_running = r_running;
            end
        endcase
        n_value = n_running ? n_remain : n_duration;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running  <= 1'b0;
            r_duration <= '0;
            r_remain   <= '0;
        end else if (w_accept) begin
            r_running  <= n_running;
            r_duration <= n_duration;
            r_remain   <= n_remain;
        end
    end

    // ------------------------------------------------------------------
    // Display pipeline.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_load[1]) begin
            r1_value <= n_value;
            r1_flags <= {n_running, (n_duration != '0)};
        end
    end

    // Whole seconds.
    assign w_prod_sec = 63'(r1_value) * 63'(RECIP_S);

    always_ff @(posedge i_clk) begin
        if (w_load[2]) begin
            r2_value <= r1_value;
            r2_sec   <= w_prod_sec[62:SHIFT_S];
            r2_flags <= r1_flags;
        end
    end

    // Milliseconds within the second, and whole minutes.
    assign w_ms_full  = {1'b0, r2_value} - (32'(r2_sec) * 32'(MS_PER_S));
    assign w_prod_min = 49'(r2_sec) * 49'(RECIP_MIN);

    always_ff @(posedge i_clk) begin
        if (w_load[3]) begin
            r3_ms    <= w_ms_full[9:0];
            r3_sec   <= r2_sec;
            r3_min   <= w_prod_min[SHIFT_MIN+15:SHIFT_MIN];
            r3_flags <= r2_flags;
        end
    end

    // Seconds within the minute, centiseconds and whole hours.
    assign w_ss_full   = r3_sec - (22'(r3_min) * 22'(S_PER_MIN));
    assign w_prod_cs   = 21'(r3_ms) * 21'(RECIP_CS);
    assign w_prod_hour = 33'(r3_min) * 33'(RECIP_HOUR);

    always_ff @(posedge i_clk) begin
        if (w_load[4]) begin
            r4_ss    <= w_ss_full[5:0];
            r4_cs    <= w_prod_cs[SHIFT_CS+6:SHIFT_CS];
            r4_min   <= r3_min;
            r4_hour  <= w_prod_hour[SHIFT_HOUR+9:SHIFT_HOUR];
            r4_flags <= r3_flags;
        end
    end

    // Minutes within the hour, and whole days.
    assign w_mm_full  = r4_min - (16'(r4_hour) * 16'(MIN_PER_HOUR));
    assign w_prod_day = 21'(r4_hour) * 21'(RECIP_DAY);

    always_ff @(posedge i_clk) begin
        if (w_load[5]) begin
            r5_ss    <= r4_ss;
            r5_cs    <= r4_cs;
            r5_mm    <= w_mm_full[5:0];
            r5_hour  <= r4_hour;
            r5_day   <= w_prod_day[SHIFT_DAY+4:SHIFT_DAY];
            r5_flags <= r4_flags;
        end
    end

    // Hours within the day pick the display format.
    assign w_hh_full = r5_hour - (10'(r5_day) * 10'(HOURS_PER_DAY));
    assign w_hh      = w_hh_full[4:0];

    always_comb begin
        if (w_hh != '0) begin
            n_out.display_high = {1'b0, w_hh};
            n_out.display_mid  = r5_mm;
            n_out.display_low  = {1'b0, r5_ss};
            n_out.hours_shown  = 1'b1;
        end else begin
            n_out.display_high = r5_mm;
            n_out.display_mid  = r5_ss;
            n_out.display_low  = r5_cs;
            n_out.hours_shown  = 1'b0;
        end
        n_out.running   = r5_flags[1];
        n_out.timer_set = r5_flags[0];
    end

    always_ff @(posedge i_clk) begin
        if (w_load[6]) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    // A running timer always has time left and a stored duration.
    a_running_has_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> (r_remain != '0) && (r_duration != '0))
        else $error("running timer with no time left");

    // A result that reports running also reports a set timer.
    a_running_implies_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.running |-> o_data.timer_set)
        else $error("running result without a set timer");

    // The digit groups stay within their display ranges.
    a_display_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.display_high <= 6'd59) && (o_data.display_mid <= 6'd59)
                    && (o_data.display_low <= 7'd99))
        else $error("display field out of range");

    // A result held at the output does not change until it is taken.
    a_output_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("held result changed");
`endif

endmodule
